// ----- rtl/core/bblfu_pkg.sv -----
`default_nettype none
package bblfu_pkg;
   localparam int LAYER_COUNT  = 64;
   localparam int EXPERT_COUNT = 256;
   localparam int SLOT_COUNT   = 16;
   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_LOADED   = 3'd1;
   localparam logic [2:0] ST_LOADFAIL = 3'd2;
   localparam logic [2:0] ST_ZERO     = 3'd3;
   localparam logic [2:0] ST_OVER     = 3'd4;
   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
   localparam logic [31:0] BUDGET_RESET = 32'd1073741824;

   typedef struct packed {
      logic clr_step;
      logic hist_wr;
      logic lookup_start;
      logic lookup_step;
      logic apply_hit;
      logic scan_start;
      logic scan_step;
      logic evict;
      logic insert;
      logic miss;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic lookup_done;
      logic hit;
      logic scan_done;
      logic any_valid;
      logic over;
      logic full;
      logic [2:0] reject;
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/core/bblfu_ctrl.sv -----
`default_nettype none
module bblfu_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output bblfu_pkg::cmd_type   cmd,
   input  wire bblfu_pkg::sts_type sts,
   output logic [2:0]           status
);
   import bblfu_pkg::*;
   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_HRD = 4'd2, S_HWR = 4'd3,
      S_LOOK = 4'd4, S_DEC = 4'd5, S_SCAN = 4'd6, S_FIT = 4'd7, S_INS = 4'd8,
      S_OUT = 4'd9;
   logic [3:0] state_ff, state_in;
   logic       lastfull_ff, lastfull_in;
   logic [2:0] status_ff, status_in;
   assign status = status_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   always_comb begin
      state_in = state_ff;
      lastfull_in = lastfull_ff;
      status_in = status_ff;
      cmd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) state_in = S_HRD;
         end
         S_HRD: begin
            state_in = S_HWR;
         end
         S_HWR: begin
            cmd.hist_wr = 1'b1;
            cmd.lookup_start = 1'b1;
            state_in = S_LOOK;
         end
         S_LOOK: begin
            cmd.lookup_step = 1'b1;
            if (sts.lookup_done) state_in = S_DEC;
         end
         S_DEC: begin
            if (sts.hit) begin
               cmd.apply_hit = 1'b1;
               status_in = ST_HIT;
               state_in = S_OUT;
            end else begin
               cmd.miss = 1'b1;
               if (sts.reject != ST_LOADED) begin
                  status_in = sts.reject;
                  state_in = S_OUT;
               end else begin
                  status_in = ST_LOADED;
                  state_in = S_FIT;
               end
            end
         end
         S_FIT: begin
            if (sts.over && sts.any_valid) begin
               lastfull_in = 1'b0;
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end else if (sts.full) begin
               lastfull_in = 1'b1;
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = S_INS;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               cmd.evict = 1'b1;
               state_in = lastfull_ff ? S_INS : S_FIT;
            end
         end
         S_INS: begin
            cmd.insert = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         lastfull_ff <= 1'b0;
         status_ff <= ST_HIT;
      end else begin
         state_ff <= state_in;
         lastfull_ff <= lastfull_in;
         status_ff <= status_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/bblfu_dp.sv -----
`default_nettype none
module bblfu_dp (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_beat,
   input  wire logic [5:0]  layer_id,
   input  wire logic [7:0]  expert_id,
   input  wire logic        load_ok,
   input  wire logic [31:0] size_bytes,
   input  wire logic        csr_wen,
   input  wire logic [31:0] csr_wdata,
   input  wire bblfu_pkg::cmd_type cmd,
   output bblfu_pkg::sts_type sts,
   output logic [3:0]       slot_index,
   output logic [4:0]       evicted_now,
   output logic [31:0]      hit_count,
   output logic [31:0]      miss_count,
   output logic [31:0]      load_count,
   output logic [31:0]      eviction_count,
   output logic [4:0]       live_slots,
   output logic [31:0]      resident_total
);
   import bblfu_pkg::*;
   localparam int LW = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
   localparam int EW = (EXPERT_COUNT > 1) ? $clog2(EXPERT_COUNT) : 1;
   localparam int KEYS = LAYER_COUNT * EXPERT_COUNT;
   localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);

   logic [31:0] hist_mem [KEYS];
   logic [31:0] hist_rd_ff;
   logic [KW:0] clr_ff;
   logic [KW-1:0] key_ff;
   logic        ok_ff;
   logic [31:0] size_ff, budget_ff, held_ff, uses_ff;
   logic [47:0] tick_ff;
   logic [31:0] hits_ff, miss_ff, loads_ff, evs_ff;
   logic [SLOT_COUNT-1:0] valid_ff;
   logic [KW-1:0] skey_mem [SLOT_COUNT];
   logic [31:0]   suses_mem [SLOT_COUNT];
   logic [47:0]   stick_mem [SLOT_COUNT];
   logic [31:0]   sbytes_mem [SLOT_COUNT];
   logic [SW:0]   idx_ff;
   logic [SW-1:0] slot_ff, best_ff;
   logic          found_ff, hit_ff;
   logic [4:0]    evn_ff;
   logic [CW-1:0] cnt_ff;
   logic [SW-1:0] idx;
   logic [SW-1:0] free_slot;
   logic [31:0]   uses_nx;
   logic          less;
   logic [LW-1:0] lay;
   logic [EW-1:0] exp;

   assign idx = idx_ff[SW-1:0];
   assign lay = LW'(32'(layer_id) % 32'(LAYER_COUNT));
   assign exp = EW'(32'(expert_id) % 32'(EXPERT_COUNT));
   assign uses_nx = (hist_rd_ff == SAT32) ? hist_rd_ff : hist_rd_ff + 32'd1;

   always_comb begin
      free_slot = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_slot = SW'(i);
      end
   end

   always_comb begin
      if (suses_mem[idx] != suses_mem[best_ff]) less = suses_mem[idx] < suses_mem[best_ff];
      else if (stick_mem[idx] != stick_mem[best_ff])
         less = stick_mem[idx] < stick_mem[best_ff];
      else less = skey_mem[idx] < skey_mem[best_ff];
   end

   always_comb begin
      sts = '0;
      sts.clr_done = (clr_ff == (KW+1)'(KEYS - 1));
      sts.lookup_done = hit_ff || (idx_ff == (SW+1)'(SLOT_COUNT));
      sts.hit = hit_ff;
      sts.scan_done = (idx_ff == (SW+1)'(SLOT_COUNT));
      sts.any_valid = |valid_ff;
      sts.over = ({1'b0, held_ff} + {1'b0, size_ff}) > {1'b0, budget_ff};
      sts.full = (cnt_ff == CW'(SLOT_COUNT));
      if (!ok_ff) sts.reject = ST_LOADFAIL;
      else if (size_ff == 32'd0) sts.reject = ST_ZERO;
      else if (size_ff > budget_ff) sts.reject = ST_OVER;
      else sts.reject = ST_LOADED;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) hist_mem[clr_ff[KW-1:0]] <= '0;
      else if (cmd.hist_wr) hist_mem[key_ff] <= uses_nx;
      hist_rd_ff <= hist_mem[key_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.apply_hit) begin
         suses_mem[slot_ff] <= uses_ff;
         stick_mem[slot_ff] <= tick_ff;
      end else if (cmd.insert) begin
         suses_mem[free_slot] <= uses_ff;
         stick_mem[free_slot] <= tick_ff;
         skey_mem[free_slot] <= key_ff;
         sbytes_mem[free_slot] <= size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         key_ff <= KW'(32'(lay) * 32'(EXPERT_COUNT) + 32'(exp));
         ok_ff <= load_ok;
         size_ff <= size_bytes;
      end
      if (cmd.hist_wr) uses_ff <= uses_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         budget_ff <= BUDGET_RESET;
         held_ff <= '0;
         tick_ff <= '0;
         hits_ff <= '0;
         miss_ff <= '0;
         loads_ff <= '0;
         evs_ff <= '0;
         valid_ff <= '0;
         idx_ff <= '0;
         slot_ff <= '0;
         best_ff <= '0;
         found_ff <= 1'b0;
         hit_ff <= 1'b0;
         evn_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (csr_wen) budget_ff <= csr_wdata;
         if (cmd.clr_step && !sts.clr_done) clr_ff <= clr_ff + (KW+1)'(1);
         if (req_beat) begin
            tick_ff <= tick_ff + 48'd1;
            evn_ff <= '0;
            slot_ff <= '0;
         end
         if (cmd.lookup_start) begin
            idx_ff <= '0;
            hit_ff <= 1'b0;
         end
         if (cmd.lookup_step && !sts.lookup_done) begin
            if (valid_ff[idx] && skey_mem[idx] == key_ff) begin
               hit_ff <= 1'b1;
               slot_ff <= idx;
            end else begin
               idx_ff <= idx_ff + (SW+1)'(1);
            end
         end
         if (cmd.apply_hit && hits_ff != SAT32) hits_ff <= hits_ff + 32'd1;
         if (cmd.miss && miss_ff != SAT32) miss_ff <= miss_ff + 32'd1;
         if (cmd.scan_start) begin
            idx_ff <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.scan_step && !sts.scan_done) begin
            if (valid_ff[idx] && (!found_ff || less)) begin
               best_ff <= idx;
               found_ff <= 1'b1;
            end
            idx_ff <= idx_ff + (SW+1)'(1);
         end
         if (cmd.evict) begin
            valid_ff[best_ff] <= 1'b0;
            held_ff <= held_ff - sbytes_mem[best_ff];
            cnt_ff <= cnt_ff - CW'(1);
            evn_ff <= evn_ff + 5'd1;
            if (evs_ff != SAT32) evs_ff <= evs_ff + 32'd1;
         end
         if (cmd.insert) begin
            valid_ff[free_slot] <= 1'b1;
            held_ff <= held_ff + size_ff;
            cnt_ff <= cnt_ff + CW'(1);
            slot_ff <= free_slot;
            if (loads_ff != SAT32) loads_ff <= loads_ff + 32'd1;
         end
      end
   end

   assign slot_index = 4'(slot_ff);
   assign evicted_now = evn_ff;
   assign hit_count = hits_ff;
   assign miss_count = miss_ff;
   assign load_count = loads_ff;
   assign eviction_count = evs_ff;
   assign live_slots = 5'(cnt_ff);
   assign resident_total = held_ff;
endmodule
`default_nettype wire

// ----- rtl/core/byte_budget_lfu_cache.sv -----
// Byte-budgeted LFU cache with LRU tie-break, one request at a time.
// req channel: req_tdata = {size_bytes, load_ok, expert_id, layer_id}, one beat
// per request. rsp channel: one beat per request carrying status, slot, and
// saturating statistics (see port comment for bit layout).
// csr_wen/csr_wdata write the byte budget; write only while idle.
// After the request beat the use history is read and updated and the SLOT_COUNT
// (16) slots are scanned serially until a hit. A hit refreshes that slot; a miss
// is rejected, or evicts (one serial slot scan per eviction) while the load
// exceeds the budget and once more if the table is full, then inserts. The next
// request beat is taken only after the response beat and the return to idle.
// Cost is set by the serial slot scans over the one compare unit.
// After reset the use-history memory is cleared, one entry a cycle, all
// LAYER_COUNT*EXPERT_COUNT (16384) entries; req_tready stays low meanwhile.
// The result is held in registers until rsp_tready; a stalled receiver holds
// the block and req_tready stays low.
`default_nettype none
module byte_budget_lfu_cache (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // layer_id[5:0], expert_id[13:6], load_ok[14], size_bytes[46:15], zero pad
   input  wire logic [47:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[2:0], slot_index[6:3], evicted_now[11:7], hit_count[43:12],
   // miss_count[75:44], load_count[107:76], eviction_count[139:108],
   // live_slots[144:140], resident_total[176:145], zero pad
   output logic [183:0]      rsp_tdata,
   input  wire logic         csr_wen,
   input  wire logic [31:0]  csr_wdata
);
   import bblfu_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic [2:0]  status;
   logic [3:0]  slot_index;
   logic [4:0]  evicted_now, live_slots;
   logic [31:0] hit_count, miss_count, load_count, eviction_count, resident_total;

   bblfu_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .sts, .status
   );

   bblfu_dp u_dp (
      .clock, .reset,
      .req_beat(req_tvalid & req_tready),
      .layer_id(req_tdata[5:0]), .expert_id(req_tdata[13:6]),
      .load_ok(req_tdata[14]), .size_bytes(req_tdata[46:15]),
      .csr_wen, .csr_wdata, .cmd, .sts,
      .slot_index, .evicted_now, .hit_count, .miss_count, .load_count,
      .eviction_count, .live_slots, .resident_total
   );

   assign rsp_tdata = {7'd0, resident_total, live_slots, eviction_count, load_count,
                       miss_count, hit_count, evicted_now, slot_index, status};
endmodule
`default_nettype wire

// ----- rtl/core/bblfu_checker.sv -----
`default_nettype none
module bblfu_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [183:0] rsp_tdata
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= 3'd4) else $error("bad status");
   a_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] >= 3'd2 |-> rsp_tdata[11:3] == 9'd0)
      else $error("reject with slot or eviction");
endmodule

bind byte_budget_lfu_cache bblfu_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
`default_nettype wire

// ----- verif/byte_budget_lfu_cache_tb.sv -----
`default_nettype none
module byte_budget_lfu_cache_tb;
   import bblfu_pkg::*;

   localparam int NSLOT = 16;
   localparam int STALL_LIMIT = 100000;

   typedef struct packed {
      logic [31:0] size_bytes;
      logic        load_ok;
      logic [7:0]  expert_id;
      logic [5:0]  layer_id;
   } req_item_type;

   typedef struct packed {
      logic [31:0] resident_total;
      logic [4:0]  live_slots;
      logic [31:0] eviction_count;
      logic [31:0] load_count;
      logic [31:0] miss_count;
      logic [31:0] hit_count;
      logic [4:0]  evicted_now;
      logic [3:0]  slot_index;
      logic [2:0]  status;
   } lookup_result_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [183:0] rsp_tdata;
   logic         csr_wen = 0;
   logic [31:0]  csr_wdata = '0;

   byte_budget_lfu_cache uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // shadow copy of the cache
   logic [31:0] use_hist [0:16383];
   logic        sh_valid [NSLOT];
   logic [13:0] sh_key [NSLOT];
   logic [31:0] sh_uses [NSLOT];
   logic [47:0] sh_tick [NSLOT];
   logic [31:0] sh_bytes [NSLOT];
   logic [47:0] tick_count;
   logic [31:0] held_bytes;
   logic [31:0] n_hit, n_miss, n_load, n_evict;
   logic [31:0] budget;

   req_item_type      pending_reqs [$];
   req_item_type      cur_req;
   lookup_result_type expected_results [$];
   int  errors = 0;
   int  n_req = 0, n_rsp = 0;
   int  idle_cycles = 0;
   bit  calm = 0;
   int  hold_left = 0;
   bit  held_once = 0;
   int  status_seen [8];

   function automatic logic [31:0] sat_up(logic [31:0] v);
      return (v == SAT32) ? v : v + 32'd1;
   endfunction

   function automatic int occupied();
      int n = 0;
      for (int i = 0; i < NSLOT; i++) if (sh_valid[i]) n++;
      return n;
   endfunction

   function automatic int victim_slot();
      int best = -1;
      for (int i = 0; i < NSLOT; i++) begin
         if (!sh_valid[i]) continue;
         if (best < 0) best = i;
         else if (sh_uses[i] != sh_uses[best]) begin
            if (sh_uses[i] < sh_uses[best]) best = i;
         end else if (sh_tick[i] != sh_tick[best]) begin
            if (sh_tick[i] < sh_tick[best]) best = i;
         end else if (sh_key[i] < sh_key[best]) best = i;
      end
      return best;
   endfunction

   function automatic void drop(int i);
      held_bytes -= sh_bytes[i];
      sh_valid[i] = 0;
      n_evict = sat_up(n_evict);
   endfunction

   function automatic lookup_result_type predict_lookup(req_item_type r);
      lookup_result_type o;
      logic [13:0] key;
      logic [31:0] uses;
      int slot, v, ev;
      bit hit;
      o = '0;
      slot = 0;
      ev = 0;
      hit = 0;
      key = {r.layer_id, r.expert_id};
      tick_count = tick_count + 48'd1;
      use_hist[key] = sat_up(use_hist[key]);
      uses = use_hist[key];
      for (int i = 0; i < NSLOT; i++)
         if (!hit && sh_valid[i] && sh_key[i] == key) begin
            hit = 1;
            slot = i;
         end
      if (hit) begin
         n_hit = sat_up(n_hit);
         sh_uses[slot] = uses;
         sh_tick[slot] = tick_count;
         o.status = ST_HIT;
      end else begin
         n_miss = sat_up(n_miss);
         if (!r.load_ok) o.status = ST_LOADFAIL;
         else if (r.size_bytes == 0) o.status = ST_ZERO;
         else if (r.size_bytes > budget) o.status = ST_OVER;
         else begin
            while ({1'b0, held_bytes} + {1'b0, r.size_bytes} > {1'b0, budget}) begin
               v = victim_slot();
               if (v < 0) break;
               drop(v);
               ev++;
            end
            if (occupied() >= NSLOT) begin
               drop(victim_slot());
               ev++;
            end
            slot = -1;
            for (int i = 0; i < NSLOT; i++) if (slot < 0 && !sh_valid[i]) slot = i;
            sh_valid[slot] = 1;
            sh_key[slot] = key;
            sh_uses[slot] = uses;
            sh_tick[slot] = tick_count;
            sh_bytes[slot] = r.size_bytes;
            held_bytes += r.size_bytes;
            n_load = sat_up(n_load);
            o.status = ST_LOADED;
         end
      end
      o.slot_index = slot[3:0];
      o.evicted_now = ev[4:0];
      o.hit_count = n_hit;
      o.miss_count = n_miss;
      o.load_count = n_load;
      o.eviction_count = n_evict;
      o.live_slots = 5'(occupied());
      o.resident_total = held_bytes;
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_results.push_back(predict_lookup(cur_req));
            n_req++;
         end
         if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
            cur_req = pending_reqs.pop_front();
            req_tdata <= {1'b0, cur_req};
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      lookup_result_type got, want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[176:0];
            n_rsp++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, got);
               errors++;
            end else begin
               want = expected_results.pop_front();
               status_seen[want.status]++;
               if (got !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, got);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 0;
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 38;
         end
      end
   end

   // receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (n_rsp == 300 && !held_once) begin
         held_once <= 1;
         hold_left <= 600;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("byte_budget_lfu_cache verification failed");
         $finish;
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(negedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_budget(logic [31:0] v);
      @(posedge clock);
      csr_wen <= 1;
      csr_wdata <= v;
      budget = v;
      @(posedge clock);
      csr_wen <= 0;
   endtask

   task automatic push_req(logic [5:0] l, logic [7:0] e, logic ok, logic [31:0] sz);
      req_item_type r;
      r.layer_id = l;
      r.expert_id = e;
      r.load_ok = ok;
      r.size_bytes = sz;
      pending_reqs.push_back(r);
   endtask

   task automatic push_random(int n, logic [31:0] max_size);
      logic [5:0] l;
      logic [7:0] e;
      logic [31:0] sz;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) begin
            l = 6'($urandom);
            e = 8'($urandom);
         end else begin
            l = 6'($urandom_range(0, 3));
            e = 8'($urandom_range(0, 7));
         end
         case ($urandom_range(19))
            0: sz = 0;
            1: sz = $urandom;
            default: sz = $urandom_range(1, max_size);
         endcase
         push_req(l, e, $urandom_range(9) != 0, sz);
      end
   endtask

   initial begin
      for (int i = 0; i < 16384; i++) use_hist[i] = 0;
      for (int i = 0; i < NSLOT; i++) begin
         sh_valid[i] = 0;
         sh_key[i] = 0;
         sh_uses[i] = 0;
         sh_tick[i] = 0;
         sh_bytes[i] = 0;
      end
      tick_count = 0;
      held_bytes = 0;
      {n_hit, n_miss, n_load, n_evict} = '0;
      budget = BUDGET_RESET;
      repeat (10) @(posedge clock);
      reset <= 0;

      push_req(0, 0, 1, 100);
      push_req(0, 0, 0, 0);
      push_req(63, 255, 0, 5);
      push_req(63, 254, 1, 0);
      push_req(62, 255, 1, 32'hFFFF_FFFF);
      push_req(1, 1, 1, BUDGET_RESET);
      push_req(0, 0, 1, 7);
      for (int i = 0; i < 17; i++) push_req(2, 8'(i), 1, 32'(1 + i));
      push_req(63, 255, 1, 1);
      drain();

      write_budget(4000);
      push_random(400, 1500);
      drain();

      write_budget(1);
      push_random(100, 2);
      drain();

      write_budget(32'hFFFF_FFFF);
      calm = 1;
      push_random(300, 32'hFFFF_FFFF);
      drain();
      calm = 0;

      write_budget(0);
      push_random(50, 3);
      drain();

      write_budget(60000);
      push_random(400, 9000);
      drain();

      $display("%0d requests, %0d responses: %0d hits, %0d loads, %0d rejects",
               n_req, n_rsp, status_seen[ST_HIT], status_seen[ST_LOADED],
               status_seen[ST_LOADFAIL] + status_seen[ST_ZERO] + status_seen[ST_OVER]);
      $display("budgets swept from 0 to all ones, %0d evictions", n_evict);
      if (errors == 0 && expected_results.size() == 0)
         $display("byte_budget_lfu_cache verification clean");
      else
         $display("byte_budget_lfu_cache verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// ----- byte_budget_lfu_cache.f -----
rtl/core/bblfu_pkg.sv
rtl/core/bblfu_ctrl.sv
rtl/core/bblfu_dp.sv
rtl/core/byte_budget_lfu_cache.sv
rtl/core/bblfu_checker.sv
verif/byte_budget_lfu_cache_tb.sv
